// ===== sv/trft_pkg.sv =====
// ============================================================================
// trft_pkg -- shared types, codes and the sine table builder
// Transaction types of both channels, register codes and the elaboration-time
// Q1.15 sine generator used by the truncated real Fourier transform block.
// ============================================================================
`default_nettype none

package trft_pkg;

   // Buffer geometry
   localparam int BUF_DEPTH  = 256;
   localparam int BUF_AW     = 8;
   localparam int DATA_W     = 32;

   // Arithmetic widths
   localparam int SINE_W     = 16;
   localparam int WEIGHT_W   = 17;
   localparam int PROD_W     = DATA_W + WEIGHT_W;
   localparam int FACTOR_W   = 11;
   localparam int CHAN_W     = 3;
   localparam int HARM_W     = 5;
   localparam int ORDER_W    = 2;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_HARMONICS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CHANNELS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIVATIVE_ORDER = 2'd3;

   localparam logic [HARM_W-1:0]  HARM_RESET = 5'd8;
   localparam logic [CHAN_W-1:0]  CHAN_RESET = 3'd1;

   // Direction, derivative and action codes
   localparam logic DIR_FORWARD  = 1'b0;
   localparam logic DIR_BACKWARD = 1'b1;

   localparam logic [ORDER_W-1:0] ORDER_NONE   = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_FIRST  = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_SECOND = 2'd2;
   localparam logic [ORDER_W-1:0] ORDER_RSVD   = 2'd3;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic signed [WEIGHT_W-1:0] MEAN_WEIGHT = 17'sd32768;

   localparam longint Q30_ONE = 64'sd1073741824;

   typedef struct packed {
      logic                     action;
      logic [BUF_AW-1:0]        position;
      logic signed [DATA_W-1:0] sample_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic                     range_error;
   } rsp_type;

   // sin(2*pi*p/2^lg) in Q1.15: odd series of sin(pi/2*t) to t^9 in Q30,
   // rounded half up to Q15, clamped to 0..32767 in the first quadrant.
   function automatic logic signed [SINE_W-1:0] sine_entry(input int p, input int lg);
      longint quarter;
      longint pm;
      longint r;
      longint t;
      longint t2;
      longint s;
      logic   neg;
      quarter = longint'(1) <<< (lg - 2);
      pm      = longint'(p) & ((longint'(1) <<< lg) - 1);
      neg     = 1'b0;
      if (pm <= quarter) begin
         r = pm;
      end else if (pm <= 2 * quarter) begin
         r = 2 * quarter - pm;
      end else if (pm <= 3 * quarter) begin
         r   = pm - 2 * quarter;
         neg = 1'b1;
      end else begin
         r   = 4 * quarter - pm;
         neg = 1'b1;
      end
      t  = r <<< (32 - lg);
      t2 = t * t / Q30_ONE;
      s  = 172272;
      s  = -5026987 + s * t2 / Q30_ONE;
      s  = 85569306 + s * t2 / Q30_ONE;
      s  = -693598666 + s * t2 / Q30_ONE;
      s  = 1686629713 + s * t2 / Q30_ONE;
      s  = s * t / Q30_ONE;
      s  = (s + 16384) / 32768;
      if (s < 0) begin
         s = 0;
      end
      if (s > 32767) begin
         s = 32767;
      end
      return neg ? SINE_W'(-s) : SINE_W'(s);
   endfunction

endpackage

`default_nettype wire

// ===== sv/trft_buffer.sv =====
// ============================================================================
// trft_buffer -- element buffer
// 256 x 32 single-port-write, registered-read storage for samples or
// coefficients.
// ============================================================================
`default_nettype none

module trft_buffer import trft_pkg::*; (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [BUF_AW-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [BUF_AW-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [BUF_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/trft_sine_rom.sv =====
// ============================================================================
// trft_sine_rom -- Q1.15 sine table
// One full period of NUM_SAMPLES entries, built at elaboration, registered read.
// ============================================================================
`default_nettype none

module trft_sine_rom import trft_pkg::*; #(
   parameter int NUM_SAMPLES = 64
) (
   input  wire logic                             clock,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(NUM_SAMPLES)-1:0]   rd_idx,
   output logic signed [SINE_W-1:0]              rd_data
);

   localparam int LG_N = $clog2(NUM_SAMPLES);

   logic signed [SINE_W-1:0] rom_table [NUM_SAMPLES];
   logic signed [SINE_W-1:0] rd_data_ff;

   for (genvar g = 0; g < NUM_SAMPLES; g++) begin : g_entry
      assign rom_table[g] = sine_entry(g, LG_N);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_table[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/truncated_real_fourier_transform.sv =====
// ============================================================================
// truncated_real_fourier_transform -- on-demand truncated real DFT engine
// Load transactions fill a 256-entry interleaved buffer; read transactions
// compute one forward coefficient (optionally differentiated) or one
// backward time sample with a single multiply-accumulate over the buffer.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  req     | in        | req_valid/req_stall  | req_data (action, position,
//          |           |                      |   sample_value)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_data (result_value,
//          |           |                      |   range_error)
//  csr     | in        | csr_write_enable     | csr_index, csr_data
//
//  Work: a load is written to the buffer as it is accepted. A read sums T
//  multiply-accumulate terms: NUM_SAMPLES forward, 2H+1 backward. All terms
//  go through the single MAC fed by one buffer read port and one sine ROM
//  port. A read past the output length, or a differentiated mean, skips the
//  MAC and answers zero after the channel divide and setup.
//  Reset: synchronous, active high; clears control and loads the register
//  defaults. The buffer is not cleared.
//  Stalls: the result register holds one finished transaction; the next
//  request is taken meanwhile, and a new result waits until the slot frees.
//
`default_nettype none

module truncated_real_fourier_transform import trft_pkg::*; #(
   parameter int NUM_SAMPLES   = 64,
   parameter int MAX_HARMONICS = 31,
   parameter int MAX_CHANNELS  = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   // configuration port
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int LG_N    = $clog2(NUM_SAMPLES);
   localparam int TERM_W  = (LG_N > 6) ? LG_N : 6;
   localparam int ACC_W   = PROD_W + TERM_W;
   localparam int VAL_W   = ACC_W - 13;
   localparam int SC_W    = VAL_W + FACTOR_W;

   // Rounding shifts: backward by 2^15, mean by 2^(15+lg N), harmonics 2^(14+lg N)
   localparam int SH_BACK_AMT = 15;
   localparam int SH_MEAN_AMT = 15 + LG_N;
   localparam int SH_HARM_AMT = 14 + LG_N;

   localparam logic [1:0] SH_BACK = 2'd0;
   localparam logic [1:0] SH_MEAN = 2'd1;
   localparam logic [1:0] SH_HARM = 2'd2;

   localparam logic [ACC_W-1:0] HALF_BACK = ACC_W'(1) << (SH_BACK_AMT - 1);
   localparam logic [ACC_W-1:0] HALF_MEAN = ACC_W'(1) << (SH_MEAN_AMT - 1);
   localparam logic [ACC_W-1:0] HALF_HARM = ACC_W'(1) << (SH_HARM_AMT - 1);

   localparam logic [LG_N-1:0]   QUARTER   = LG_N'(NUM_SAMPLES / 4);
   localparam logic [TERM_W-1:0] FWD_LAST  = TERM_W'(NUM_SAMPLES - 1);

   // Sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DIVIDE = 4'd1;
   localparam logic [3:0] ST_SETUP  = 4'd2;
   localparam logic [3:0] ST_RUN    = 4'd3;
   localparam logic [3:0] ST_DRAIN  = 4'd4;
   localparam logic [3:0] ST_ROUND  = 4'd5;
   localparam logic [3:0] ST_SHIFT  = 4'd6;
   localparam logic [3:0] ST_SCALE  = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   logic [3:0]                state_ff, state_in;

   logic [HARM_W-1:0]         csr_harm_ff, csr_harm_in;
   logic [CHAN_W-1:0]         csr_chan_ff, csr_chan_in;
   logic                      csr_dir_ff, csr_dir_in;
   logic [ORDER_W-1:0]        csr_order_ff, csr_order_in;

   logic [CHAN_W-1:0]         chan_ff, chan_in;
   logic [HARM_W-1:0]         harm_ff, harm_in;
   logic                      dir_ff, dir_in;
   logic [ORDER_W-1:0]        order_ff, order_in;

   logic [CHAN_W-1:0]         div_rem_ff, div_rem_in;
   logic [BUF_AW-1:0]         div_quot_ff, div_quot_in;
   logic [2:0]                div_cnt_ff, div_cnt_in;

   logic [BUF_AW-1:0]         addr_ff, addr_in;
   logic [LG_N-1:0]           phase_ff, phase_in;
   logic [LG_N-1:0]           step_ff, step_in;
   logic [TERM_W-1:0]         term_ff, term_in;
   logic [TERM_W-1:0]         last_term_ff, last_term_in;
   logic                      is_mean_ff, is_mean_in;
   logic                      use_sin_ff, use_sin_in;
   logic signed [FACTOR_W-1:0] factor_ff, factor_in;
   logic [1:0]                shift_sel_ff, shift_sel_in;

   logic                      iss_vld_ff, iss_vld_in;
   logic                      iss_const_ff, iss_const_in;
   logic                      prod_vld_ff, prod_vld_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      neg_ff, neg_in;
   logic [ACC_W-1:0]          mag_ff, mag_in;
   logic signed [VAL_W-1:0]   val_ff, val_in;
   logic signed [SC_W-1:0]    scaled_ff, scaled_in;
   logic                      err_ff, err_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   // ------------------------------------------------------------------------
   // Combinational helpers
   // ------------------------------------------------------------------------
   logic                      req_accept;
   logic                      buf_wr_en;
   logic [DATA_W-1:0]         buf_q;
   logic signed [SINE_W-1:0]  rom_q;
   logic                      issue;
   logic                      issue_const;
   logic [LG_N-1:0]           rom_idx;

   logic [HARM_W-1:0]         harm_clamped;
   logic [CHAN_W-1:0]         chan_clamped;
   logic [ORDER_W-1:0]        order_clamped;

   logic [CHAN_W:0]           div_shifted;
   logic [CHAN_W+1:0]         div_trial;
   logic                      div_bit;

   logic [BUF_AW-1:0]         item_k;
   logic [HARM_W-1:0]         harm_k;
   logic [2*HARM_W-1:0]       harm_sq;
   logic                      in_range;

   logic [LG_N-1:0]           phase_plus_step;

   logic signed [PROD_W-1:0]  buf_ext;
   logic signed [PROD_W-1:0]  wt_ext;
   logic signed [WEIGHT_W-1:0] weight;

   logic [ACC_W-1:0]          acc_abs;
   logic [ACC_W-1:0]          half_sel;
   logic [ACC_W-1:0]          mag_shifted;
   logic [VAL_W-1:0]          val_mag;

   logic signed [SC_W-1:0]    val_ext;
   logic signed [SC_W-1:0]    factor_ext;
   logic                      sat_ok;
   logic signed [DATA_W-1:0]  sat_value;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign buf_wr_en  = req_accept && (req_data.action == ACT_LOAD);

   // Effective configuration: zero channels means one; clamp to the maxima
   always_comb begin
      if (csr_chan_ff == '0) begin
         chan_clamped = CHAN_W'(1);
      end else if (32'(csr_chan_ff) > MAX_CHANNELS) begin
         chan_clamped = CHAN_W'(MAX_CHANNELS);
      end else begin
         chan_clamped = csr_chan_ff;
      end
      if (32'(csr_harm_ff) > MAX_HARMONICS) begin
         harm_clamped = HARM_W'(MAX_HARMONICS);
      end else begin
         harm_clamped = csr_harm_ff;
      end
      order_clamped = (csr_order_ff == ORDER_RSVD) ? ORDER_NONE : csr_order_ff;
   end

   // One restoring divide step: position / channels, one quotient bit a cycle
   assign div_shifted = {div_rem_ff, div_quot_ff[BUF_AW-1]};
   assign div_trial   = {1'b0, div_shifted} - {2'b00, chan_ff};
   assign div_bit     = !div_trial[CHAN_W+1];

   // Setup decode of the item index k = position / channels
   assign item_k   = div_quot_ff;
   assign harm_k   = HARM_W'(item_k[BUF_AW-1:1] + 7'(item_k[0]));
   assign harm_sq  = {5'b0, harm_k} * {5'b0, harm_k};
   assign in_range = (dir_ff == DIR_BACKWARD) ? (32'(item_k) < NUM_SAMPLES)
                                              : (9'(item_k) < {3'b000, harm_ff, 1'b1});

   // Term issue: forward walks phase by h, backward by n before each cosine term
   assign phase_plus_step = phase_ff + step_ff;
   assign issue           = (state_ff == ST_RUN);

   always_comb begin
      if (dir_ff == DIR_FORWARD) begin
         issue_const = is_mean_ff;
         rom_idx     = use_sin_ff ? phase_ff : phase_ff + QUARTER;
      end else if (term_ff == '0) begin
         issue_const = 1'b1;
         rom_idx     = phase_ff;
      end else if (term_ff[0]) begin
         issue_const = 1'b0;
         rom_idx     = phase_plus_step + QUARTER;
      end else begin
         issue_const = 1'b0;
         rom_idx     = phase_ff;
      end
   end

   // MAC operands
   assign weight  = iss_const_ff ? MEAN_WEIGHT : {rom_q[SINE_W-1], rom_q};
   assign buf_ext = PROD_W'($signed(buf_q));
   assign wt_ext  = PROD_W'(weight);

   // Rounding half away from zero
   assign acc_abs = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

   always_comb begin
      unique case (shift_sel_ff)
         SH_MEAN: begin
            half_sel    = HALF_MEAN;
            mag_shifted = mag_ff >> SH_MEAN_AMT;
         end
         SH_HARM: begin
            half_sel    = HALF_HARM;
            mag_shifted = mag_ff >> SH_HARM_AMT;
         end
         default: begin
            half_sel    = HALF_BACK;
            mag_shifted = mag_ff >> SH_BACK_AMT;
         end
      endcase
   end

   assign val_mag    = VAL_W'(mag_shifted);
   assign val_ext    = SC_W'(val_ff);
   assign factor_ext = SC_W'(factor_ff);

   // Saturate to the signed 32-bit range
   assign sat_ok    = (&scaled_ff[SC_W-1:DATA_W-1]) || !(|scaled_ff[SC_W-1:DATA_W-1]);
   assign sat_value = sat_ok ? DATA_W'(scaled_ff)
                             : (scaled_ff[SC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                  : {1'b0, {(DATA_W-1){1'b1}}});

   // ------------------------------------------------------------------------
   // Next-state logic
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      csr_harm_in   = csr_harm_ff;
      csr_chan_in   = csr_chan_ff;
      csr_dir_in    = csr_dir_ff;
      csr_order_in  = csr_order_ff;
      chan_in       = chan_ff;
      harm_in       = harm_ff;
      dir_in        = dir_ff;
      order_in      = order_ff;
      div_rem_in    = div_rem_ff;
      div_quot_in   = div_quot_ff;
      div_cnt_in    = div_cnt_ff;
      addr_in       = addr_ff;
      phase_in      = phase_ff;
      step_in       = step_ff;
      term_in       = term_ff;
      last_term_in  = last_term_ff;
      is_mean_in    = is_mean_ff;
      use_sin_in    = use_sin_ff;
      factor_in     = factor_ff;
      shift_sel_in  = shift_sel_ff;
      iss_vld_in    = issue;
      iss_const_in  = issue_const;
      prod_vld_in   = iss_vld_ff;
      prod_in       = buf_ext * wt_ext;
      acc_in        = prod_vld_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      val_in        = val_ff;
      scaled_in     = scaled_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      // Register writes (the user must write only while idle; the block does not enforce it)
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NUM_HARMONICS:    csr_harm_in  = csr_data[HARM_W-1:0];
            CSR_NUM_CHANNELS:     csr_chan_in  = csr_data[CHAN_W-1:0];
            CSR_DIRECTION:        csr_dir_in   = csr_data[0];
            CSR_DERIVATIVE_ORDER: csr_order_in = csr_data[ORDER_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Latch position into the divider and snapshot the configuration
            if (req_accept && (req_data.action == ACT_READ)) begin
               chan_in     = chan_clamped;
               harm_in     = harm_clamped;
               dir_in      = csr_dir_ff;
               order_in    = order_clamped;
               div_rem_in  = '0;
               div_quot_in = req_data.position;
               div_cnt_in  = '0;
               state_in    = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            div_rem_in  = div_bit ? div_trial[CHAN_W-1:0] : div_shifted[CHAN_W-1:0];
            div_quot_in = {div_quot_ff[BUF_AW-2:0], div_bit};
            div_cnt_in  = div_cnt_ff + 3'd1;
            if (div_cnt_ff == 3'd7) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            addr_in    = BUF_AW'(div_rem_ff);
            phase_in   = '0;
            term_in    = '0;
            acc_in     = '0;
            is_mean_in = (item_k == '0);
            use_sin_in = (order_ff == ORDER_FIRST) ? item_k[0] : !item_k[0];
            err_in     = !in_range;
            if (dir_ff == DIR_BACKWARD) begin
               step_in      = LG_N'(item_k);
               last_term_in = TERM_W'({harm_ff, 1'b0});
               factor_in    = FACTOR_W'(1);
               shift_sel_in = SH_BACK;
            end else begin
               step_in      = LG_N'(harm_k);
               last_term_in = FWD_LAST;
               shift_sel_in = (item_k == '0) ? SH_MEAN : SH_HARM;
               unique case (order_ff)
                  ORDER_FIRST:  factor_in = item_k[0] ? FACTOR_W'({1'b0, harm_k})
                                                      : -FACTOR_W'({1'b0, harm_k});
                  ORDER_SECOND: factor_in = -FACTOR_W'({1'b0, harm_sq});
                  default:      factor_in = FACTOR_W'(1);
               endcase
            end
            // Out of range, or a differentiated mean: answer zero at once
            if (!in_range || ((dir_ff == DIR_FORWARD) && (item_k == '0)
                              && (order_ff != ORDER_NONE))) begin
               scaled_in = '0;
               state_in  = ST_DONE;
            end else begin
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            addr_in = addr_ff + BUF_AW'(chan_ff);
            term_in = term_ff + TERM_W'(1);
            if (dir_ff == DIR_FORWARD) begin
               phase_in = phase_plus_step;
            end else if (term_ff[0]) begin
               phase_in = phase_plus_step;
            end
            if (term_ff == last_term_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Wait for the last product to land in the accumulator
            if (!iss_vld_ff && !prod_vld_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            neg_in   = acc_ff[ACC_W-1];
            mag_in   = acc_abs + half_sel;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            val_in   = neg_ff ? -VAL_W'(val_mag) : VAL_W'(val_mag);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            scaled_in = val_ext * factor_ext;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the result slot is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_value = sat_value;
               rsp_data_in.range_error  = err_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequential
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_harm_ff  <= HARM_RESET;
         csr_chan_ff  <= CHAN_RESET;
         csr_dir_ff   <= DIR_FORWARD;
         csr_order_ff <= ORDER_NONE;
         iss_vld_ff   <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_harm_ff  <= csr_harm_in;
         csr_chan_ff  <= csr_chan_in;
         csr_dir_ff   <= csr_dir_in;
         csr_order_ff <= csr_order_in;
         iss_vld_ff   <= iss_vld_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff      <= chan_in;
      harm_ff      <= harm_in;
      dir_ff       <= dir_in;
      order_ff     <= order_in;
      div_rem_ff   <= div_rem_in;
      div_quot_ff  <= div_quot_in;
      div_cnt_ff   <= div_cnt_in;
      addr_ff      <= addr_in;
      phase_ff     <= phase_in;
      step_ff      <= step_in;
      term_ff      <= term_in;
      last_term_ff <= last_term_in;
      is_mean_ff   <= is_mean_in;
      use_sin_ff   <= use_sin_in;
      factor_ff    <= factor_in;
      shift_sel_ff <= shift_sel_in;
      iss_const_ff <= iss_const_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      val_ff       <= val_in;
      scaled_ff    <= scaled_in;
      err_ff       <= err_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // ------------------------------------------------------------------------
   // Storage
   // ------------------------------------------------------------------------
   trft_buffer u_buffer (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (req_data.position),
      .wr_data (req_data.sample_value),
      .rd_en   (issue),
      .rd_addr (addr_ff),
      .rd_data (buf_q)
   );

   trft_sine_rom #(
      .NUM_SAMPLES (NUM_SAMPLES)
   ) u_sine_rom (
      .clock   (clock),
      .rd_en   (issue),
      .rd_idx  (rom_idx),
      .rd_data (rom_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
